// ===== rtl/range_add_count_below_assert.svh =====
// Assertion macros shared by the range add / count below block.
// Included by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef RANGE_ADD_COUNT_BELOW_ASSERT_SVH
`define RANGE_ADD_COUNT_BELOW_ASSERT_SVH
`ifndef ASSERT_OFF
// Plain property check, disabled during reset
`define RACB_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// Same-cycle implication check, disabled during reset
`define RACB_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication check, disabled during reset
`define RACB_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define RACB_ASSERT(lbl, ck, rn, prop, msg)
`define RACB_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define RACB_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ===== rtl/racb_pkg.sv =====
// Package for the range add / count below block: operation codes, FSM states,
// field widths and the broadcast command struct. No dependencies.
`default_nettype none

package racb_pkg;

    localparam int POS_W  = 10;   // position field width
    localparam int LEN_W  = 11;   // length register width
    localparam int OPND_W = 32;   // operand width
    localparam int DATA_W = 64;   // stored element width

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_ADD   = 2'd1,
        FN_COUNT = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    // Command held steady while the token walks the cell row
    typedef struct packed {
        func_t                     func;
        logic                      active;
        logic [POS_W-1:0]          lo;
        logic [POS_W-1:0]          hi;
        logic signed [DATA_W-1:0]  value;   // load value, addend or threshold
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/racb_cell.sv =====
// One element cell of the row: holds a 64-bit value and passes the token
// and running count on to its neighbour. Depends on racb_pkg.
`default_nettype none

module racb_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 11
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire racb_pkg::cmd_t    cmd,
    input  wire                    tok_in,
    input  wire [CNT_W-1:0]        cnt_in,
    output logic                   tok_out,
    output logic [CNT_W-1:0]       cnt_out
);
    import racb_pkg::*;

    localparam logic             IN_POS = (CELL_IDX < (2 ** POS_W));
    localparam logic [POS_W-1:0] POS    = POS_W'(CELL_IDX);

    logic signed [DATA_W-1:0] data_reg;
    logic                     tok_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     hit;
    logic                     below;

    // This cell is addressed by the passing command
    assign hit   = tok_in && cmd.active && IN_POS && (POS >= cmd.lo) && (POS <= cmd.hi);
    assign below = (data_reg < cmd.value);

    always_comb
    begin
        cnt_next = cnt_in;
        if (hit && (cmd.func == FN_COUNT) && below)
        begin
            cnt_next = cnt_in + CNT_W'(1);
        end
    end

    // Element storage: written when the token passes with a load or add
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            case (cmd.func)
                FN_LOAD: data_reg <= cmd.value;
                FN_ADD:  data_reg <= data_reg + cmd.value;
                default: data_reg <= data_reg;
            endcase
        end
    end

    // Token and running count to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
            cnt_reg <= cnt_next;
        end
    end

    assign tok_out = tok_reg;
    assign cnt_out = cnt_reg;

endmodule

`default_nettype wire

// ===== rtl/range_add_count_below.sv =====
// Top level of the range add / count below block: command port, length
// register, setup stage and the row of racb_cell. Depends on racb_pkg and the assert header.
`default_nettype none

// Keeps DEPTH signed 64-bit elements in a row of cells. A transaction is taken
// when start is high and busy is low; func selects load, range add or range
// count of elements strictly below operand squared. Every load, add or count
// keeps busy high from acceptance through these steps: the setup state forms
// the clipped range and the squared threshold, then a token walks the cell row
// one cell per cycle, and the result is registered as busy drops again.
// func 3 is taken and dropped at once. A count result appears on count for a
// single cycle with count_valid high and cannot be held off by the receiver.
// cfg_we writes length_in_use; do so only while busy is low. Elements must be
// loaded before a range reads them.

module range_add_count_below #(
    parameter int DEPTH = 1024
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire [1:0]                           func,
    input  wire [racb_pkg::POS_W-1:0]           left,
    input  wire [racb_pkg::POS_W-1:0]           right,
    input  wire signed [racb_pkg::OPND_W-1:0]   operand,
    input  wire                                 cfg_we,
    input  wire [racb_pkg::LEN_W-1:0]           cfg_wdata,
    output logic                                count_valid,
    output logic [$clog2(DEPTH+1)-1:0]          count
);
    import racb_pkg::*;

    `include "range_add_count_below_assert.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [LEN_W-1:0] LEN_CAP =
        (DEPTH < (2 ** LEN_W)) ? LEN_W'(DEPTH) : '1;

    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         length_reg;
    func_t                    func_reg;
    logic [POS_W-1:0]         lo_reg;
    logic [POS_W-1:0]         hi_reg;
    logic signed [OPND_W-1:0] opnd_reg;
    cmd_t                     cmd_reg, cmd_next;
    logic                     inject_reg, inject_next;
    logic                     res_valid_reg, res_valid_next;
    logic [CNT_W-1:0]         res_count_reg, res_count_next;
    logic                     accept;

    logic [LEN_W-1:0]         len_eff;
    logic [LEN_W-1:0]         lo_x;
    logic [LEN_W-1:0]         hi_x;
    logic [LEN_W-1:0]         hi_cut;
    logic [OPND_W-1:0]        mag;
    logic [DATA_W-1:0]        square;

    logic                     tok_chain [DEPTH+1];
    logic [CNT_W-1:0]         cnt_chain [DEPTH+1];

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            length_reg <= cfg_wdata;
        end
    end

    // Capture the transaction fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(func);
            lo_reg   <= left;
            hi_reg   <= right;
            opnd_reg <= operand;
        end
    end

    // Setup arithmetic: clipped range and squared threshold
    always_comb
    begin
        len_eff = (length_reg > LEN_CAP) ? LEN_CAP : length_reg;
        lo_x    = LEN_W'(lo_reg);
        hi_x    = LEN_W'(hi_reg);
        hi_cut  = ((len_eff != '0) && (hi_x >= len_eff)) ? (len_eff - LEN_W'(1)) : hi_x;
        mag     = opnd_reg[OPND_W-1] ? (~opnd_reg + OPND_W'(1)) : opnd_reg;
        square  = DATA_W'(mag) * DATA_W'(mag);
    end

    // Control FSM: next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        inject_next    = 1'b0;
        res_valid_next = 1'b0;
        res_count_next = res_count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func_t'(func) != FN_NONE))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd_next.func = func_reg;
                cmd_next.lo   = lo_reg;
                if (func_reg == FN_LOAD)
                begin
                    cmd_next.active = (lo_x < len_eff);
                    cmd_next.hi     = lo_reg;
                    cmd_next.value  = DATA_W'(opnd_reg);
                end
                else
                begin
                    cmd_next.active = (len_eff != '0) && (lo_x <= hi_cut);
                    cmd_next.hi     = hi_cut[POS_W-1:0];
                    cmd_next.value  = (func_reg == FN_COUNT) ? $signed(square)
                                                             : DATA_W'(opnd_reg);
                end
                inject_next = 1'b1;
                state_next  = ST_RUN;
            end
            ST_RUN:
            begin
                if (tok_chain[DEPTH])
                begin
                    res_valid_next = (cmd_reg.func == FN_COUNT);
                    res_count_next = cnt_chain[DEPTH];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            inject_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inject_reg    <= inject_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        res_count_reg <= res_count_next;
    end

    // Row of element cells; the token enters at cell 0
    assign tok_chain[0] = inject_reg;
    assign cnt_chain[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        racb_cell #(
            .CELL_IDX (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd_reg),
            .tok_in  (tok_chain[i]),
            .cnt_in  (cnt_chain[i]),
            .tok_out (tok_chain[i+1]),
            .cnt_out (cnt_chain[i+1])
        );
    end

    assign count_valid = res_valid_reg;
    assign count       = res_count_reg;

    // Checks
    `RACB_ASSERT_IMP(a_result_idle, clk, rst_n, count_valid, !busy, "result while busy")
    `RACB_ASSERT_IMP(a_inject_run, clk, rst_n, inject_reg, state_reg == ST_RUN, "token outside run")
    `RACB_ASSERT_IMP(a_tail_run, clk, rst_n, tok_chain[DEPTH], state_reg == ST_RUN, "stray token at tail")
    `RACB_ASSERT_NXT(a_start_busy, clk, rst_n, accept && (func_t'(func) != FN_NONE), busy, "accepted transaction not busy")
    `RACB_ASSERT(a_one_token, clk, rst_n, !(inject_reg && tok_chain[DEPTH]), "two tokens in row")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for range_add_count_below: load, range add and range count
// commands checked against a scoreboard that keeps its own copy of the element array.
// Depends on racb_pkg and the range_add_count_below RTL.
`timescale 1ns / 100ps

module testbench;

    import racb_pkg::*;

    localparam int          DEPTH_TB       = 1024;
    localparam int          CLK_HALF       = 6;
    localparam int          RESET_CYCLES   = 12;
    localparam int          MAX_GAP        = 14;
    localparam int          SETTLE_CYCLES  = DEPTH_TB + 8;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          REPORT_LIMIT   = 10;
    localparam int          PHASE_ITEMS    = 66;
    localparam logic [OPND_W-1:0] OPND_MIN = 32'h8000_0000;
    localparam logic [OPND_W-1:0] OPND_MAX = 32'h7FFF_FFFF;

    // Predicts count results from its own copy of the element array
    class range_count_board;
        logic signed [DATA_W-1:0] cells [DEPTH_TB];
        int unsigned              length_reg;
        logic [LEN_W-1:0]         pending_counts [$];
        int unsigned              failures;
        int unsigned              checked;

        function new();
            foreach (cells[i]) cells[i] = '0;
            length_reg = LEN_RESET;
            failures   = 0;
            checked    = 0;
        endfunction

        // Number of positions actually in use
        function int unsigned span();
            return (length_reg < DEPTH_TB) ? length_reg : DEPTH_TB;
        endfunction

        function void set_length(logic [LEN_W-1:0] value);
            length_reg = value;
        endfunction

        // Apply one accepted transaction and queue the count it will produce
        function void note_command(func_t f, logic [POS_W-1:0] lo, logic [POS_W-1:0] hi,
                                   logic signed [OPND_W-1:0] opnd);
            int unsigned              eff;
            int unsigned              top;
            int unsigned              n;
            logic signed [DATA_W-1:0] wide;
            logic signed [DATA_W-1:0] thr;
            eff  = span();
            wide = opnd;
            thr  = wide * wide;
            top  = (eff != 0 && hi >= eff) ? eff - 1 : hi;
            n    = 0;
            case (f)
                FN_LOAD:
                    if (lo < eff) cells[lo] = wide;
                FN_ADD:
                    if (eff != 0)
                        for (int i = lo; i <= top; i++) cells[i] = cells[i] + wide;
                FN_COUNT:
                begin
                    if (eff != 0)
                        for (int i = lo; i <= top; i++)
                            if (cells[i] < thr) n++;
                    pending_counts = {pending_counts, n[LEN_W-1:0]};
                end
                default: ;
            endcase
        endfunction

        // Compare one strobed count with the oldest prediction
        function void check_count(logic [LEN_W-1:0] got);
            logic [LEN_W-1:0] want;
            if (pending_counts.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected count result %0d with nothing pending", got);
                return;
            end
            want = pending_counts.pop_front();
            checked++;
            if (got !== want)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("count mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                func;
    logic [POS_W-1:0]          left;
    logic [POS_W-1:0]          right;
    logic signed [OPND_W-1:0]  operand;
    logic                      cfg_we;
    logic [LEN_W-1:0]          cfg_wdata;
    logic                      count_valid;
    logic [LEN_W-1:0]          count;

    range_count_board board;
    bit               loaded [DEPTH_TB];
    int unsigned      commands_sent;
    int unsigned      length_writes;
    int unsigned      idle_run;

    range_add_count_below #(
        .DEPTH(DEPTH_TB)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .left       (left),
        .right      (right),
        .operand    (operand),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .count_valid(count_valid),
        .count      (count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && count_valid)
            board.check_count(count);
    end

    // Watchdog: cycles with no transaction of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || count_valid || cfg_we)
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("** range_add_count_below: FAILED **");
            $finish;
        end
    end

    // Operand for loads and adds: extremes, small values, full range
    function automatic logic signed [OPND_W-1:0] pick_operand();
        int unsigned sel;
        int          small_val;
        sel       = $urandom_range(0, 9);
        small_val = int'($urandom_range(0, 40)) - 20;
        case (sel)
            0:       return OPND_MIN;
            1:       return OPND_MAX;
            2, 3:    return small_val;
            default: return $urandom;
        endcase
    endfunction

    // Operand for counts: square roots on the scale of the stored values
    function automatic logic signed [OPND_W-1:0] pick_threshold();
        int unsigned sel;
        int          mag;
        sel = $urandom_range(0, 9);
        mag = $urandom_range(0, 65536);
        case (sel)
            0:          return OPND_MIN;
            1:          return OPND_MAX;
            2:          return '0;
            3, 4, 5:    return $urandom_range(0, 1) ? mag : -mag;
            6, 7:       return $urandom_range(0, 25);
            default:    return $urandom;
        endcase
    endfunction

    // Range whose in-use part is fully loaded, or an empty one
    task automatic pick_range(output logic [POS_W-1:0] lo, output logic [POS_W-1:0] hi);
        int unsigned eff;
        int unsigned p;
        int unsigned a;
        int unsigned b;
        int unsigned tries;
        bit          found;
        eff   = board.span();
        found = 1'b0;
        if (eff == 0)
        begin
            lo = $urandom_range(0, DEPTH_TB - 1);
            hi = $urandom_range(0, DEPTH_TB - 1);
            return;
        end
        if ($urandom_range(0, 9) != 0)
        begin
            for (tries = 0; tries < 48 && !found; tries++)
            begin
                p = $urandom_range(0, eff - 1);
                found = loaded[p];
            end
            for (tries = 0; tries < eff && !found; tries++)
                if (loaded[tries])
                begin
                    p = tries;
                    found = 1'b1;
                end
        end
        if (!found)
        begin
            // empty: reversed range, or a start beyond the length in use
            if (eff < DEPTH_TB && $urandom_range(0, 1))
            begin
                lo = $urandom_range(eff, DEPTH_TB - 1);
                hi = $urandom_range(0, DEPTH_TB - 1);
            end
            else
            begin
                lo = $urandom_range(1, DEPTH_TB - 1);
                hi = $urandom_range(0, lo - 1);
            end
            return;
        end
        a = p;
        b = p;
        while (a > 0 && loaded[a-1]) a--;
        while (b < eff - 1 && loaded[b+1]) b++;
        lo = $urandom_range(a, p);
        if (b == eff - 1 && $urandom_range(0, 1))
            hi = $urandom_range(p, DEPTH_TB - 1);   // cut at the length in use
        else
            hi = $urandom_range(p, b);
    endtask

    // Drive one command and wait for it to be taken
    task automatic send_item(input func_t f, input logic [POS_W-1:0] lo,
                             input logic [POS_W-1:0] hi, input logic signed [OPND_W-1:0] opnd,
                             input int unsigned gap);
        if (gap > 0)
        begin
            @(negedge clk) start <= 1'b0;
            if ($urandom_range(0, 3) == 0)
            begin
                @(posedge clk);
                while (busy) @(posedge clk);
            end
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        func    <= f;
        left    <= lo;
        right   <= hi;
        operand <= opnd;
        do @(posedge clk); while (busy);
        if (f == FN_LOAD && lo < board.span())
            loaded[lo] = 1'b1;
        board.note_command(f, lo, hi, opnd);
        commands_sent++;
    endtask

    // Let the block drain, then write the length register
    task automatic write_length(input logic [LEN_W-1:0] value);
        @(negedge clk) start <= 1'b0;
        while (board.pending_counts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        board.set_length(value);
        length_writes++;
        @(negedge clk) cfg_we <= 1'b0;
    endtask

    task automatic directed_item(input func_t f, input logic [POS_W-1:0] lo,
                                 input logic [POS_W-1:0] hi, input logic signed [OPND_W-1:0] opnd);
        send_item(f, lo, hi, opnd, $urandom_range(0, MAX_GAP));
    endtask

    // Mostly well-formed traffic with some noise, at one length setting
    task automatic random_phase(input int unsigned target, input bit burst);
        int unsigned              done;
        int unsigned              pick;
        int unsigned              eff;
        int unsigned              win;
        logic [POS_W-1:0]         lo;
        logic [POS_W-1:0]         hi;
        logic signed [OPND_W-1:0] opnd;
        func_t                    f;
        done = 0;
        win  = $urandom_range(0, DEPTH_TB - 1);
        while (done < target)
        begin
            eff  = board.span();
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                f    = FN_NONE;
                lo   = $urandom_range(0, DEPTH_TB - 1);
                hi   = $urandom_range(0, DEPTH_TB - 1);
                opnd = $urandom;
            end
            else if (pick < 40)
            begin
                f  = FN_LOAD;
                hi = $urandom_range(0, DEPTH_TB - 1);
                if (eff == 0 || (pick < 7 && eff < DEPTH_TB))
                    lo = $urandom_range(eff < DEPTH_TB ? eff : 0, DEPTH_TB - 1);
                else if (pick < 24)
                    lo = $urandom_range(0, eff - 1);
                else
                    lo = (win + $urandom_range(0, 31)) % eff;
                opnd = pick_operand();
            end
            else
            begin
                f = (pick < 68) ? FN_ADD : FN_COUNT;
                pick_range(lo, hi);
                opnd = (f == FN_ADD) ? pick_operand() : pick_threshold();
            end
            send_item(f, lo, hi, opnd, burst ? 0 : $urandom_range(0, MAX_GAP));
            if (f != FN_NONE && !(f == FN_LOAD && lo >= eff))
                done++;
        end
    endtask

    // Stimulus
    initial
    begin
        logic [LEN_W-1:0] phase_len [8];
        board         = new();
        commands_sent = 0;
        length_writes = 0;
        idle_run      = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        func          = FN_LOAD;
        left          = '0;
        right         = '0;
        operand       = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed: short array holding the operand extremes
        write_length(11'd8);
        directed_item(FN_LOAD, 10'd0, 10'd0, OPND_MIN);
        directed_item(FN_LOAD, 10'd1, 10'd1023, OPND_MAX);
        directed_item(FN_LOAD, 10'd2, 10'd0, 32'sd0);
        directed_item(FN_LOAD, 10'd3, 10'd0, -32'sd1);
        directed_item(FN_LOAD, 10'd4, 10'd0, 32'sd5);
        directed_item(FN_LOAD, 10'd5, 10'd0, 32'sd1);
        directed_item(FN_LOAD, 10'd6, 10'd0, 32'sd100);
        directed_item(FN_LOAD, 10'd7, 10'd0, -32'sd100);
        // load past the length in use is dropped
        directed_item(FN_LOAD, 10'd1023, 10'd1023, 32'sd77);
        directed_item(FN_COUNT, 10'd0, 10'd1023, 32'sd0);
        directed_item(FN_COUNT, 10'd0, 10'd1023, OPND_MIN);
        directed_item(FN_COUNT, 10'd0, 10'd7, OPND_MAX);
        directed_item(FN_ADD, 10'd2, 10'd5, OPND_MAX);
        directed_item(FN_ADD, 10'd0, 10'd1023, OPND_MIN);
        directed_item(FN_COUNT, 10'd0, 10'd7, -32'sd1);
        // empty ranges: reversed, and starting past the length
        directed_item(FN_COUNT, 10'd5, 10'd3, 32'sd10);
        directed_item(FN_COUNT, 10'd8, 10'd1023, OPND_MIN);
        directed_item(FN_NONE, 10'd1023, 10'd1023, -32'sd1);
        // zero length: nothing is in use
        write_length(11'd0);
        directed_item(FN_LOAD, 10'd0, 10'd0, 32'sd9);
        directed_item(FN_ADD, 10'd0, 10'd1023, 32'sd3);
        directed_item(FN_COUNT, 10'd0, 10'd1023, OPND_MIN);
        // register above the depth: the whole array is in use
        write_length(11'd2047);
        directed_item(FN_LOAD, 10'd1023, 10'd0, -32'sd5);
        directed_item(FN_COUNT, 10'd1023, 10'd1023, 32'sd3);
        directed_item(FN_ADD, 10'd1023, 10'd1023, OPND_MAX);
        directed_item(FN_COUNT, 10'd1023, 10'd1023, 32'sd0);

        // Random phases over a spread of lengths
        phase_len[0] = 11'd1;
        phase_len[1] = 11'd6;
        phase_len[2] = 11'd1024;
        phase_len[3] = 11'd40;
        phase_len[4] = 11'd2047;
        phase_len[5] = 11'd1000;
        phase_len[6] = 11'd2;
        phase_len[7] = $urandom_range(1, 2047);
        foreach (phase_len[i])
        begin
            write_length(phase_len[i]);
            random_phase(PHASE_ITEMS, (i % 3) == 1);
        end

        // Drain and let the last command finish
        @(negedge clk) start <= 1'b0;
        while (board.pending_counts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d commands across %0d length writes (0, 1, 2 ... 2047); %0d counts checked.",
                 commands_sent, length_writes, board.checked);
        $display("Mismatches or unexpected results: %0d.", board.failures);
        if (board.failures == 0 && board.pending_counts.size() == 0)
            $display("** range_add_count_below: PASSED **");
        else
            $display("** range_add_count_below: FAILED **");
        $finish;
    end

endmodule
